// ----- src/cau_pkg.sv -----
// Shared constants, codes and helper functions of the complex arithmetic unit.
package cau_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int MAX_EXPONENT = 16;

    // One in Q15.16, pi in Q2.30, pi at the output scale, inverse CORDIC gain in Q2.30.
    localparam logic signed [31:0] ONE       = 32'sd65536;
    localparam logic signed [35:0] PI_Q30    = 36'sd3373259426;
    localparam logic signed [35:0] PI_Q      = 36'sd205887;
    localparam logic signed [32:0] INV_GAIN  = 33'sd652032874;

    // Action codes.
    localparam logic [2:0] ACT_POLAR = 3'd0;
    localparam logic [2:0] ACT_ADD   = 3'd1;
    localparam logic [2:0] ACT_SUB   = 3'd2;
    localparam logic [2:0] ACT_MUL   = 3'd3;
    localparam logic [2:0] ACT_DIV   = 3'd4;
    localparam logic [2:0] ACT_POW   = 3'd5;

    // Status codes.
    localparam logic [1:0] STATUS_OK  = 2'd0;
    localparam logic [1:0] STATUS_DZ  = 2'd1;
    localparam logic [1:0] STATUS_OVF = 2'd2;

    // Saturates a wide signed value to 32 bits; the top bit flags saturation.
    function automatic logic [32:0] sat_dw(input logic signed [65:0] v);
        logic [32:0] r;
        if (v > 66'sd2147483647) begin
            r = {1'b1, 32'h7FFF_FFFF};
        end else if (v < -66'sd2147483648) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

    // Arctangent of 2^-i in Q2.30, truncated.
    function automatic logic [29:0] atan_q30(input logic [3:0] i);
        logic [29:0] r;
        case (i)
            4'd0:    r = 30'h3243F6A8;
            4'd1:    r = 30'h1DAC6705;
            4'd2:    r = 30'h0FADBAFC;
            4'd3:    r = 30'h07F56EA6;
            4'd4:    r = 30'h03FEAB76;
            4'd5:    r = 30'h01FFD55B;
            4'd6:    r = 30'h00FFFAAA;
            4'd7:    r = 30'h007FFF55;
            4'd8:    r = 30'h003FFFEA;
            4'd9:    r = 30'h001FFFFD;
            4'd10:   r = 30'h000FFFFF;
            4'd11:   r = 30'h0007FFFF;
            4'd12:   r = 30'h0003FFFF;
            4'd13:   r = 30'h0001FFFF;
            4'd14:   r = 30'h0000FFFF;
            4'd15:   r = 30'h00007FFF;
            default: r = 30'h0;
        endcase
        return r;
    endfunction

endpackage

// ----- src/cau_if.sv -----
// Valid/ready channel interfaces for operand beats and result beats.
interface cau_in_if;
    logic               valid;
    logic               ready;
    logic        [2:0]  action;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
    logic signed [5:0]  exponent;

    modport source (output valid, action, a_re, a_im, b_re, b_im, exponent, input ready);
    modport sink   (input valid, action, a_re, a_im, b_re, b_im, exponent, output ready);
endinterface

interface cau_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] res_re;
    logic signed [31:0] res_im;
    logic        [30:0] magnitude;
    logic signed [18:0] angle;
    logic        [1:0]  status;

    modport source (output valid, res_re, res_im, magnitude, angle, status, input ready);
    modport sink   (input valid, res_re, res_im, magnitude, angle, status, output ready);
endinterface

// ----- src/complex_arithmetic_unit.sv -----
// Complex arithmetic unit: sequenced shared multiplier, divider and CORDIC.
//
//  channel  | direction | payload
//  ---------+-----------+------------------------------------------------
//  i_in     | in        | action, a_re, a_im, b_re, b_im, exponent
//  o_out    | out       | res_re, res_im, magnitude, angle, status
//
// Add, subtract and polar run the 16 CORDIC steps and the gain multiply. A multiply
// first forms its products on the shared 33x33 multiplier, a divide its products
// plus two 80-step restoring divisions, a power one complex product per factor plus
// a divide for a negative exponent. i_in is ready only while idle; the result
// sits in an output register, so the next beat is taken while it waits.
// Reset is synchronous and active low and clears the sequencer and output valid.
module complex_arithmetic_unit (
    input logic       i_clk,
    input logic       i_rst_n,
    cau_in_if.sink    i_in,
    cau_out_if.source o_out
);

    typedef enum logic [2:0] {
        S_IDLE, S_PROD, S_DIV, S_CORD_INIT, S_CORD, S_GAIN, S_FIN
    } t_state;

    t_state             r_state;
    logic        [2:0]  r_act;
    logic signed [31:0] r_pr, r_pi, r_qr, r_qi, r_rr, r_ri;
    logic        [4:0]  r_pow;
    logic               r_neg_exp, r_is_div, r_dsel, r_dneg, r_ovf, r_dz;
    logic        [2:0]  r_cnt;
    logic signed [65:0] r_prod, r_acc_re, r_acc_im;
    logic        [63:0] r_den, r_rem;
    logic        [79:0] r_dvd;
    logic        [6:0]  r_dcnt;
    logic signed [35:0] r_cx, r_cy, r_cz;
    logic        [3:0]  r_it;
    logic        [30:0] r_mag;
    logic signed [18:0] r_ang;
    logic               r_o_valid;
    logic signed [31:0] r_o_re, r_o_im;
    logic        [30:0] r_o_mag;
    logic signed [18:0] r_o_ang;
    logic        [1:0]  r_o_status;

    logic signed [32:0] w_mul_a, w_mul_b;
    logic signed [65:0] w_prod;
    logic        [32:0] w_add_re, w_add_im, w_sub_re, w_sub_im, w_sre, w_sim;
    logic signed [5:0]  w_e;
    logic        [4:0]  w_eabs;
    logic        [2:0]  w_idx;
    logic               w_b_zero;
    logic        [65:0] w_trial;
    logic signed [65:0] w_nabs, w_mround;
    logic        [31:0] w_qval;
    logic               w_qovf;
    logic signed [35:0] w_dx, w_dy, w_atan, w_zr;
    logic signed [35:0] w_x0, w_y0;

    // Shared multiplier operand selection.
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            S_PROD: begin
                case ({r_is_div, r_cnt})
                    4'b0_000: begin w_mul_a = 33'(r_pr); w_mul_b = 33'(r_qr); end
                    4'b0_001: begin w_mul_a = 33'(r_pi); w_mul_b = 33'(r_qi); end
                    4'b0_010: begin w_mul_a = 33'(r_pr); w_mul_b = 33'(r_qi); end
                    4'b0_011: begin w_mul_a = 33'(r_pi); w_mul_b = 33'(r_qr); end
                    4'b1_000: begin w_mul_a = 33'(r_qr); w_mul_b = 33'(r_qr); end
                    4'b1_001: begin w_mul_a = 33'(r_qi); w_mul_b = 33'(r_qi); end
                    4'b1_010: begin w_mul_a = 33'(r_pr); w_mul_b = 33'(r_qr); end
                    4'b1_011: begin w_mul_a = 33'(r_pi); w_mul_b = 33'(r_qi); end
                    4'b1_100: begin w_mul_a = 33'(r_pi); w_mul_b = 33'(r_qr); end
                    4'b1_101: begin w_mul_a = 33'(r_pr); w_mul_b = 33'(r_qi); end
                    default: begin w_mul_a = '0; w_mul_b = '0; end
                endcase
            end
            S_GAIN: begin
                w_mul_b = cau_pkg::INV_GAIN;
                if (r_cnt == 3'd0) begin
                    w_mul_a = {13'b0, r_cx[35:16]};
                end else begin
                    w_mul_a = {17'b0, r_cx[15:0]};
                end
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;
    assign w_idx  = r_cnt - 3'd1;

    // Add and subtract of the incoming beat.
    assign w_add_re = cau_pkg::sat_dw(66'(i_in.a_re) + 66'(i_in.b_re));
    assign w_add_im = cau_pkg::sat_dw(66'(i_in.a_im) + 66'(i_in.b_im));
    assign w_sub_re = cau_pkg::sat_dw(66'(i_in.a_re) - 66'(i_in.b_re));
    assign w_sub_im = cau_pkg::sat_dw(66'(i_in.a_im) - 66'(i_in.b_im));
    assign w_b_zero = (i_in.b_re == 0) && (i_in.b_im == 0);

    // Exponent magnitude, clamped to the largest supported power.
    assign w_e = i_in.exponent;
    always_comb begin
        if (w_e > 6'(cau_pkg::MAX_EXPONENT) || w_e < -6'(cau_pkg::MAX_EXPONENT)) begin
            w_eabs = 5'(cau_pkg::MAX_EXPONENT);
        end else if (w_e < 0) begin
            w_eabs = 5'(-w_e);
        end else begin
            w_eabs = 5'(w_e);
        end
    end

    // Scaled and saturated complex product.
    assign w_sre = cau_pkg::sat_dw(r_acc_re >>> cau_pkg::FRAC_BITS);
    assign w_sim = cau_pkg::sat_dw(r_acc_im >>> cau_pkg::FRAC_BITS);

    // Divider: imaginary numerator magnitude, one restoring step, quotient saturation.
    assign w_nabs  = (r_acc_im < 0) ? -r_acc_im : r_acc_im;
    assign w_trial = {1'b0, r_rem, r_dvd[79]} - {2'b0, r_den};
    always_comb begin
        if (r_dneg) begin
            w_qovf = r_dvd > 80'd2147483648;
            w_qval = w_qovf ? 32'h8000_0000 : -r_dvd[31:0];
        end else begin
            w_qovf = r_dvd > 80'd2147483647;
            w_qval = w_qovf ? 32'h7FFF_FFFF : r_dvd[31:0];
        end
    end

    // CORDIC step terms, start vector and output scaling.
    assign w_dx     = r_cy >>> r_it;
    assign w_dy     = r_cx >>> r_it;
    assign w_atan   = 36'(cau_pkg::atan_q30(r_it));
    assign w_x0     = 36'(r_rr);
    assign w_y0     = 36'(r_ri);
    assign w_mround = (r_acc_re + 66'sd536870912) >>> 30;
    assign w_zr     = (r_cz + 36'sd8192) >>> 14;

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_o_valid;
    assign o_out.res_re    = r_o_re;
    assign o_out.res_im    = r_o_im;
    assign o_out.magnitude = r_o_mag;
    assign o_out.angle     = r_o_ang;
    assign o_out.status    = r_o_status;

    // Sequencer and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            if (o_out.ready && r_state != S_FIN) begin
                r_o_valid <= 1'b0;
            end
            r_prod <= w_prod;
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_act     <= i_in.action;
                        r_pr      <= (i_in.action == cau_pkg::ACT_POW) ? cau_pkg::ONE
                                                                       : i_in.a_re;
                        r_pi      <= (i_in.action == cau_pkg::ACT_POW) ? 32'sd0 : i_in.a_im;
                        r_qr      <= (i_in.action == cau_pkg::ACT_POW) ? i_in.a_re : i_in.b_re;
                        r_qi      <= (i_in.action == cau_pkg::ACT_POW) ? i_in.a_im : i_in.b_im;
                        r_ovf     <= (i_in.action == cau_pkg::ACT_ADD) ?
                                         (w_add_re[32] | w_add_im[32]) :
                                     (i_in.action == cau_pkg::ACT_SUB) ?
                                         (w_sub_re[32] | w_sub_im[32]) : 1'b0;
                        r_dz      <= (i_in.action == cau_pkg::ACT_DIV) && w_b_zero;
                        r_mag     <= '0;
                        r_ang     <= '0;
                        r_cnt     <= '0;
                        r_acc_re  <= '0;
                        r_acc_im  <= '0;
                        r_den     <= '0;
                        r_is_div  <= (i_in.action == cau_pkg::ACT_DIV) && !w_b_zero;
                        r_neg_exp <= w_e < 0;
                        case (i_in.action)
                            cau_pkg::ACT_POLAR: begin
                                r_rr    <= i_in.a_re;
                                r_ri    <= i_in.a_im;
                                r_state <= S_CORD_INIT;
                            end
                            cau_pkg::ACT_ADD: begin
                                r_rr    <= w_add_re[31:0];
                                r_ri    <= w_add_im[31:0];
                                r_state <= S_CORD_INIT;
                            end
                            cau_pkg::ACT_SUB: begin
                                r_rr    <= w_sub_re[31:0];
                                r_ri    <= w_sub_im[31:0];
                                r_state <= S_CORD_INIT;
                            end
                            cau_pkg::ACT_MUL: begin
                                r_state <= S_PROD;
                            end
                            cau_pkg::ACT_DIV: begin
                                if (w_b_zero) begin
                                    r_rr    <= '0;
                                    r_ri    <= '0;
                                    r_state <= S_FIN;
                                end else begin
                                    r_state <= S_PROD;
                                end
                            end
                            cau_pkg::ACT_POW: begin
                                r_rr <= cau_pkg::ONE;
                                r_ri <= '0;
                                if (w_eabs == 5'd0) begin
                                    r_state <= S_CORD_INIT;
                                end else begin
                                    r_pow   <= w_eabs - 5'd1;
                                    r_state <= S_PROD;
                                end
                            end
                            default: begin
                                r_rr    <= '0;
                                r_ri    <= '0;
                                r_state <= S_FIN;
                            end
                        endcase
                    end
                end
                S_PROD: begin
                    r_cnt <= (!r_is_div && r_cnt == 3'd5) ? 3'd0 : r_cnt + 3'd1;
                    // Accumulate the product held in r_prod from the previous issue.
                    if (r_cnt != 3'd0) begin
                        case ({r_is_div, w_idx})
                            4'b0_000: r_acc_re <= r_acc_re + r_prod;
                            4'b0_001: r_acc_re <= r_acc_re - r_prod;
                            4'b0_010: r_acc_im <= r_acc_im + r_prod;
                            4'b0_011: r_acc_im <= r_acc_im + r_prod;
                            4'b1_000: r_den    <= r_den + r_prod[63:0];
                            4'b1_001: r_den    <= r_den + r_prod[63:0];
                            4'b1_010: r_acc_re <= r_acc_re + r_prod;
                            4'b1_011: r_acc_re <= r_acc_re + r_prod;
                            4'b1_100: r_acc_im <= r_acc_im + r_prod;
                            4'b1_101: r_acc_im <= r_acc_im - r_prod;
                            default: begin
                            end
                        endcase
                    end
                    if (!r_is_div && r_cnt == 3'd5) begin
                        // Complex product done.
                        r_rr     <= w_sre[31:0];
                        r_ri     <= w_sim[31:0];
                        r_ovf    <= r_ovf | w_sre[32] | w_sim[32];
                        r_acc_re <= '0;
                        r_acc_im <= '0;
                        if (r_act == cau_pkg::ACT_POW && r_pow != 5'd0) begin
                            r_pow <= r_pow - 5'd1;
                            r_pr  <= w_sre[31:0];
                            r_pi  <= w_sim[31:0];
                        end else if (r_act == cau_pkg::ACT_POW && r_neg_exp) begin
                            if (w_sre[31:0] == 32'd0 && w_sim[31:0] == 32'd0) begin
                                r_dz    <= 1'b1;
                                r_state <= S_FIN;
                            end else begin
                                r_pr     <= cau_pkg::ONE;
                                r_pi     <= '0;
                                r_qr     <= w_sre[31:0];
                                r_qi     <= w_sim[31:0];
                                r_den    <= '0;
                                r_is_div <= 1'b1;
                            end
                        end else begin
                            r_state <= S_CORD_INIT;
                        end
                    end else if (r_is_div && r_cnt == 3'd7) begin
                        // Numerators and denominator ready: start the real part.
                        r_dsel  <= 1'b0;
                        r_dneg  <= r_acc_re < 0;
                        r_dvd   <= {(r_acc_re < 0) ? 64'(-r_acc_re) : r_acc_re[63:0], 16'b0};
                        r_rem   <= '0;
                        r_dcnt  <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_dcnt != 7'd80) begin
                        r_dcnt <= r_dcnt + 7'd1;
                        if (!w_trial[65]) begin
                            r_rem <= w_trial[63:0];
                            r_dvd <= {r_dvd[78:0], 1'b1};
                        end else begin
                            r_rem <= {r_rem[62:0], r_dvd[79]};
                            r_dvd <= {r_dvd[78:0], 1'b0};
                        end
                    end else begin
                        r_ovf <= r_ovf | w_qovf;
                        if (!r_dsel) begin
                            // Real part done, run the imaginary part.
                            r_rr   <= w_qval;
                            r_dsel <= 1'b1;
                            r_dneg <= r_acc_im < 0;
                            r_dvd  <= {w_nabs[63:0], 16'b0};
                            r_rem  <= '0;
                            r_dcnt <= '0;
                        end else begin
                            r_ri    <= w_qval;
                            r_state <= S_CORD_INIT;
                        end
                    end
                end
                S_CORD_INIT: begin
                    r_it <= '0;
                    if (r_rr == 32'd0 && r_ri == 32'd0) begin
                        r_mag   <= '0;
                        r_ang   <= '0;
                        r_state <= S_FIN;
                    end else begin
                        // Fold the left half plane onto the right one.
                        if (r_rr < 0) begin
                            r_cx <= -w_x0;
                            r_cy <= -w_y0;
                            r_cz <= (r_ri >= 0) ? cau_pkg::PI_Q30 : -cau_pkg::PI_Q30;
                        end else begin
                            r_cx <= w_x0;
                            r_cy <= w_y0;
                            r_cz <= '0;
                        end
                        r_state <= S_CORD;
                    end
                end
                S_CORD: begin
                    if (r_cy < 0) begin
                        r_cx <= r_cx - w_dx;
                        r_cy <= r_cy + w_dy;
                        r_cz <= r_cz - w_atan;
                    end else begin
                        r_cx <= r_cx + w_dx;
                        r_cy <= r_cy - w_dy;
                        r_cz <= r_cz + w_atan;
                    end
                    if (r_it == 4'(cau_pkg::CORDIC_STEPS - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_GAIN;
                    end else begin
                        r_it <= r_it + 4'd1;
                    end
                end
                S_GAIN: begin
                    // Modulus times inverse gain as two partial products.
                    r_cnt <= r_cnt + 3'd1;
                    case (r_cnt)
                        3'd1: r_acc_re <= r_prod <<< 16;
                        3'd2: r_acc_re <= r_acc_re + r_prod;
                        3'd3: begin
                            if (w_mround > 66'sd2147483647) begin
                                r_mag <= 31'h7FFF_FFFF;
                                r_ovf <= 1'b1;
                            end else begin
                                r_mag <= w_mround[30:0];
                            end
                            if (w_zr > cau_pkg::PI_Q) begin
                                r_ang <= 19'(cau_pkg::PI_Q);
                            end else if (w_zr < -cau_pkg::PI_Q) begin
                                r_ang <= 19'(-cau_pkg::PI_Q);
                            end else begin
                                r_ang <= w_zr[18:0];
                            end
                            r_state <= S_FIN;
                        end
                        default: begin
                        end
                    endcase
                end
                S_FIN: begin
                    if (!r_o_valid || o_out.ready) begin
                        r_o_valid <= 1'b1;
                        r_o_re    <= r_dz ? 32'sd0 : r_rr;
                        r_o_im    <= r_dz ? 32'sd0 : r_ri;
                        r_o_mag   <= r_dz ? 31'd0 : r_mag;
                        r_o_ang   <= r_dz ? 19'sd0 : r_ang;
                        r_o_status <= r_dz ? cau_pkg::STATUS_DZ :
                                      (r_ovf ? cau_pkg::STATUS_OVF : cau_pkg::STATUS_OK);
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // A division-by-zero beat carries an all-zero result.
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_status == cau_pkg::STATUS_DZ) |->
        (r_o_re == 0 && r_o_im == 0 && r_o_mag == 0 && r_o_ang == 0))
        else $error("division by zero beat with nonzero result");

    // The angle stays within plus and minus pi.
    a_ang_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (36'(r_o_ang) <= cau_pkg::PI_Q && 36'(r_o_ang) >= -cau_pkg::PI_Q))
        else $error("angle out of range");

    // An accepted beat leaves the idle state.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state != S_IDLE))
        else $error("sequencer idle after accept");

    // A finished result waits while the output register is still full.
    a_fin_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_o_valid && !o_out.ready) |=> (r_state == S_FIN))
        else $error("result overwrote a pending beat");

endmodule

// ----- tb/cau_test_if.sv -----
`timescale 1ns / 1ps
// Interface definitions live in src/cau_if.sv; this file holds the beat record types used by the test.
package cau_test_pkg;

    // One operand beat as the stimulus side and the checker see it.
    typedef struct packed {
        logic        [2:0]  action;
        logic signed [31:0] a_re;
        logic signed [31:0] a_im;
        logic signed [31:0] b_re;
        logic signed [31:0] b_im;
        logic signed [5:0]  exponent;
    } t_operand_beat;

    // One result beat.
    typedef struct packed {
        logic signed [31:0] res_re;
        logic signed [31:0] res_im;
        logic        [30:0] magnitude;
        logic signed [18:0] angle;
        logic        [1:0]  status;
    } t_result_beat;

endpackage

// ----- tb/cau_checker.sv -----
`timescale 1ns / 1ps
// Checker that predicts each result beat from its operand beat and compares them.
module cau_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cau_in_if           i_in,
    cau_out_if          i_out,
    output int          o_fail_count,
    output int          o_pending
);

    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;

    cau_test_pkg::t_result_beat expected_results[$];
    int                         mismatch_count;

    assign o_fail_count = mismatch_count;
    assign o_pending    = expected_results.size();

    // Arithmetic shift right on 64-bit signed values.
    function automatic longint shr(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint clamp32(input longint v, inout bit ovf);
        if (v > SAT_HI) begin
            ovf = 1'b1;
            return SAT_HI;
        end
        if (v < SAT_LO) begin
            ovf = 1'b1;
            return SAT_LO;
        end
        return v;
    endfunction

    // floor((p1 + p2) / 2^16), done with wide arithmetic to avoid overflow.
    function automatic longint floor_sum(input longint p1, input longint p2);
        logic signed [65:0] s;
        s = 66'(signed'(p1)) + 66'(signed'(p2));
        s = s >>> cau_pkg::FRAC_BITS;
        return longint'(s);
    endfunction

    function automatic void complex_mul(input longint ar, input longint ai,
                                        input longint br, input longint bi,
                                        output longint rr, output longint ri,
                                        inout bit ovf);
        rr = clamp32(floor_sum(ar * br, -(ai * bi)), ovf);
        ri = clamp32(floor_sum(ar * bi, ai * br), ovf);
    endfunction

    // (p1 + p2) * 2^16 / den, truncated toward zero, saturated.
    function automatic longint scaled_quotient(input longint p1, input longint p2,
                                               input logic [63:0] den, inout bit ovf);
        logic signed [65:0] s;
        logic [65:0]        mag;
        logic [81:0]        q;
        bit                 neg;
        s   = 66'(signed'(p1)) + 66'(signed'(p2));
        neg = s < 0;
        mag = neg ? -s : s;
        q   = ({16'b0, mag} << cau_pkg::FRAC_BITS) / den;
        if (!neg && q > 82'd2147483647) begin
            ovf = 1'b1;
            return SAT_HI;
        end
        if (neg && q > 82'd2147483648) begin
            ovf = 1'b1;
            return SAT_LO;
        end
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic void complex_div(input longint ar, input longint ai,
                                        input longint br, input longint bi,
                                        output longint rr, output longint ri,
                                        inout bit ovf, inout bit dz);
        logic [63:0] den;
        rr = 0;
        ri = 0;
        if (br == 0 && bi == 0) begin
            dz = 1'b1;
            return;
        end
        den = 64'(br * br) + 64'(bi * bi);
        rr  = scaled_quotient(ar * br, ai * bi, den, ovf);
        ri  = scaled_quotient(ai * br, -(ar * bi), den, ovf);
    endfunction

    // CORDIC vectoring: modulus and argument of a rectangular value.
    function automatic void to_polar(input longint x_in, input longint y_in,
                                     output longint mag, output longint ang,
                                     inout bit ovf);
        longint x, y, z, dx, dy, m, a, pi_q;
        x    = x_in;
        y    = y_in;
        z    = 0;
        pi_q = shr(longint'(cau_pkg::PI_Q30) + (64'sd1 <<< 13), 14);
        mag  = 0;
        ang  = 0;
        if (x == 0 && y == 0) return;
        if (x < 0) begin
            z = (y >= 0) ? longint'(cau_pkg::PI_Q30) : -longint'(cau_pkg::PI_Q30);
            x = -x;
            y = -y;
        end
        for (int i = 0; i < cau_pkg::CORDIC_STEPS; i++) begin
            dx = shr(y, i);
            dy = shr(x, i);
            if (y < 0) begin
                x -= dx;
                y += dy;
                z -= longint'(cau_pkg::atan_q30(4'(i)));
            end else begin
                x += dx;
                y -= dy;
                z += longint'(cau_pkg::atan_q30(4'(i)));
            end
        end
        m = shr(x * longint'(cau_pkg::INV_GAIN) + (64'sd1 <<< 29), 30);
        if (m < 0) m = 0;
        if (m > SAT_HI) begin
            m   = SAT_HI;
            ovf = 1'b1;
        end
        a = shr(z + (64'sd1 <<< 13), 14);
        if (a > pi_q) a = pi_q;
        if (a < -pi_q) a = -pi_q;
        mag = m;
        ang = a;
    endfunction

    // Computes the result beat that one operand beat should produce.
    function automatic cau_test_pkg::t_result_beat predict_result(
        input cau_test_pkg::t_operand_beat op);
        cau_test_pkg::t_result_beat r;
        longint ar, ai, br, bi, rr, ri, nr, ni, mag, ang, e, t;
        bit     ovf, dz, known;
        ar = op.a_re;
        ai = op.a_im;
        br = op.b_re;
        bi = op.b_im;
        e  = op.exponent;
        rr = 0;
        ri = 0;
        mag = 0;
        ang = 0;
        ovf = 1'b0;
        dz  = 1'b0;
        known = 1'b1;
        case (op.action)
            cau_pkg::ACT_POLAR: begin
                rr = ar;
                ri = ai;
            end
            cau_pkg::ACT_ADD: begin
                rr = clamp32(ar + br, ovf);
                ri = clamp32(ai + bi, ovf);
            end
            cau_pkg::ACT_SUB: begin
                rr = clamp32(ar - br, ovf);
                ri = clamp32(ai - bi, ovf);
            end
            cau_pkg::ACT_MUL: complex_mul(ar, ai, br, bi, rr, ri, ovf);
            cau_pkg::ACT_DIV: complex_div(ar, ai, br, bi, rr, ri, ovf, dz);
            cau_pkg::ACT_POW: begin
                if (e > cau_pkg::MAX_EXPONENT) e = cau_pkg::MAX_EXPONENT;
                if (e < -cau_pkg::MAX_EXPONENT) e = -cau_pkg::MAX_EXPONENT;
                rr = cau_pkg::ONE;
                ri = 0;
                for (int k = 0; k < (e < 0 ? -e : e); k++) begin
                    complex_mul(rr, ri, ar, ai, nr, ni, ovf);
                    rr = nr;
                    ri = ni;
                end
                if (e < 0) begin
                    t = rr;
                    complex_div(cau_pkg::ONE, 0, t, ri, rr, ri, ovf, dz);
                end
            end
            default: known = 1'b0;
        endcase
        if (dz) begin
            rr = 0;
            ri = 0;
        end else if (known) begin
            to_polar(rr, ri, mag, ang, ovf);
        end
        r.res_re    = rr[31:0];
        r.res_im    = ri[31:0];
        r.magnitude = mag[30:0];
        r.angle     = ang[18:0];
        r.status    = dz ? cau_pkg::STATUS_DZ :
                      (ovf ? cau_pkg::STATUS_OVF : cau_pkg::STATUS_OK);
        return r;
    endfunction

    // Predict on every accepted operand beat and check every accepted result beat.
    always @(posedge i_clk) begin
        cau_test_pkg::t_operand_beat op;
        cau_test_pkg::t_result_beat  got;
        cau_test_pkg::t_result_beat  want;
        if (!i_rst_n) begin
            mismatch_count <= 0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                op = '{i_in.action, i_in.a_re, i_in.a_im, i_in.b_re, i_in.b_im,
                       i_in.exponent};
                expected_results.push_back(predict_result(op));
            end
            if (i_out.valid && i_out.ready) begin
                got = '{i_out.res_re, i_out.res_im, i_out.magnitude, i_out.angle,
                        i_out.status};
                if (expected_results.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("Unexpected result beat %h", got);
                    mismatch_count <= mismatch_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        if (mismatch_count < 10)
                            $display("Mismatch: re %h/%h im %h/%h mag %h/%h ang %h/%h st %0d/%0d",
                                     want.res_re, got.res_re, want.res_im, got.res_im,
                                     want.magnitude, got.magnitude, want.angle, got.angle,
                                     want.status, got.status);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ----- tb/complex_arithmetic_unit_test.sv -----
`timescale 1ns / 1ps
// Top of the test: clock, reset, operand stimulus, result back-pressure and verdict.
module complex_arithmetic_unit_test;

    localparam int RANDOM_BEATS = 1750;
    localparam int CYCLE_LIMIT  = 5_000_000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    bit   hold_off;
    bit   stimulus_done;

    cau_in_if  in_ch ();
    cau_out_if out_ch ();

    complex_arithmetic_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    cau_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Timeout guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Random gap length: mostly short, now and then long.
    function automatic int gap_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) return 0;
        if (pick < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 120);
    endfunction

    function automatic logic [31:0] random_value();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 131072)) - 65536);
            2: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            4: return 32'd0;
            default: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
        endcase
    endfunction

    // Drives one operand beat and waits until it is accepted.
    task automatic send_operand(input cau_test_pkg::t_operand_beat op);
        in_ch.valid    <= 1'b1;
        in_ch.action   <= op.action;
        in_ch.a_re     <= op.a_re;
        in_ch.a_im     <= op.a_im;
        in_ch.b_re     <= op.b_re;
        in_ch.b_im     <= op.b_im;
        in_ch.exponent <= op.exponent;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic idle_input(input int cycles);
        if (cycles > 0) begin
            in_ch.valid <= 1'b0;
            repeat (cycles) @(negedge i_clk);
        end
    endtask

    function automatic cau_test_pkg::t_operand_beat make_beat(
        input logic [2:0] act, input logic [31:0] ar,
        input logic [31:0] ai, input logic [31:0] br,
        input logic [31:0] bi, input logic [5:0] e);
        cau_test_pkg::t_operand_beat op;
        op = '{act, ar, ai, br, bi, e};
        return op;
    endfunction

    // Result side: random stalls, plus one long hold-off while operands keep coming.
    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            stall = gap_length();
            if (hold_off) begin
                out_ch.ready <= 1'b0;
            end else if ($urandom_range(0, 99) < 20 && stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        hold_off = 1'b0;
        wait (stimulus_done == 1'b0 && cycle_count > 3000);
        hold_off = 1'b1;
        repeat (1500) @(negedge i_clk);
        hold_off = 1'b0;
    end

    // Operand stimulus and verdict.
    initial begin
        cau_test_pkg::t_operand_beat op;
        int                          drain;
        stimulus_done  = 1'b0;
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.action   = cau_pkg::ACT_POLAR;
        in_ch.a_re     = '0;
        in_ch.a_im     = '0;
        in_ch.b_re     = '0;
        in_ch.b_im     = '0;
        in_ch.exponent = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed beats: extremes, each action, and the special cases.
        send_operand(make_beat(cau_pkg::ACT_POLAR, 32'h0, 32'h0, 32'h0, 32'h0, 6'd0));
        send_operand(make_beat(cau_pkg::ACT_POLAR, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
                               32'h0, 6'd0));
        send_operand(make_beat(cau_pkg::ACT_POLAR, 32'h8000_0000, 32'h0, 32'h0, 32'h0,
                               6'd0));
        send_operand(make_beat(cau_pkg::ACT_POLAR, 32'hFFFF_0000, 32'hFFFF_FFFF, 32'h0,
                               32'h0, 6'd0));
        send_operand(make_beat(cau_pkg::ACT_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                               32'h8000_0000, 6'd0));
        send_operand(make_beat(cau_pkg::ACT_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                               32'h8000_0000, 6'd0));
        send_operand(make_beat(cau_pkg::ACT_MUL, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000,
                               32'h0001_8000, 6'd0));
        send_operand(make_beat(cau_pkg::ACT_MUL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                               32'h8000_0000, 6'd0));
        send_operand(make_beat(cau_pkg::ACT_DIV, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0,
                               6'd0));
        send_operand(make_beat(cau_pkg::ACT_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
                               32'h0, 6'd0));
        send_operand(make_beat(cau_pkg::ACT_DIV, 32'h0003_0000, 32'hFFFE_0000, 32'h0001_0000,
                               32'h0002_0000, 6'd0));
        send_operand(make_beat(cau_pkg::ACT_POW, 32'h0, 32'h0, 32'h0, 32'h0, 6'd0));
        send_operand(make_beat(cau_pkg::ACT_POW, 32'h0, 32'h0, 32'h0, 32'h0, -6'sd3));
        send_operand(make_beat(cau_pkg::ACT_POW, 32'h0000_0100, 32'h0, 32'h0, 32'h0, -6'sd4));
        send_operand(make_beat(cau_pkg::ACT_POW, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0,
                               6'd16));
        send_operand(make_beat(cau_pkg::ACT_POW, 32'h0000_F000, 32'h0000_4000, 32'h0, 32'h0,
                               6'sd31));
        send_operand(make_beat(cau_pkg::ACT_POW, 32'h0001_2000, 32'hFFFF_C000, 32'h0, 32'h0,
                               6'h20));
        send_operand(make_beat(cau_pkg::ACT_POW, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0,
                               6'd2));
        send_operand(make_beat(3'd6, 32'h1234_5678, 32'h1, 32'h2, 32'h3, 6'd1));
        send_operand(make_beat(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                               32'hFFFF_FFFF, 6'h3F));

        // Random beats with random gaps, sent back to back in the last 50 of every 200.
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            op.action   = ($urandom_range(0, 49) == 0) ? 3'($urandom_range(6, 7))
                                                       : 3'($urandom_range(0, 5));
            op.a_re     = random_value();
            op.a_im     = random_value();
            op.b_re     = ($urandom_range(0, 29) == 0) ? 32'd0 : random_value();
            op.b_im     = ($urandom_range(0, 29) == 0) ? 32'd0 : random_value();
            op.exponent = ($urandom_range(0, 9) == 0) ? 6'($urandom)
                                                      : 6'($signed($urandom_range(0, 32)) - 16);
            send_operand(op);
            if (n % 200 < 150) idle_input(gap_length());
        end
        in_ch.valid   <= 1'b0;
        stimulus_done  = 1'b1;

        // Drain, then wait on so that any surplus result beat is still seen.
        drain = 0;
        while (pending != 0 && drain < 200000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (400) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
